[src/scbt_pkg.sv]
// scbt_pkg: shared types and fixed constants for the shaft cull box test.
// No dependencies.
package scbt_pkg;

    localparam int TOL_W     = 23;
    localparam int LOAD_W    = 52;
    localparam int SLOT_W    = 5;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BND_SLOTS = 18;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_BOUND  = 2'd0,
        CMD_LOAD_NORMAL = 2'd1,
        CMD_LOAD_OFFSET = 2'd2,
        CMD_TEST        = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE   = 2'd0,
        CFG_PLANAR_2D   = 2'd1,
        CFG_PLANE_COUNT = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // load beat as seen by the storage holders
    typedef struct packed {
        logic              we;
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [LOAD_W-1:0] value;
    } t_load;

    // test token walking down the cell chain
    typedef struct packed {
        logic vld;
        logic alive;   // inside extent, no end box hit, no plane culled yet
        logic h1;
        logic h2;
    } t_tok;

endpackage

[src/scbt_if.sv]
// scbt_req_if / scbt_rsp_if: valid/ready channels of the shaft cull box test.
// Depends on scbt_pkg.
interface scbt_req_if
    import scbt_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             command;
    logic [SLOT_W-1:0]            slot;
    logic signed [LOAD_W-1:0]     load_value;
    logic signed [COORD_BITS-1:0] query_xmin;
    logic signed [COORD_BITS-1:0] query_ymin;
    logic signed [COORD_BITS-1:0] query_zmin;
    logic signed [COORD_BITS-1:0] query_xmax;
    logic signed [COORD_BITS-1:0] query_ymax;
    logic signed [COORD_BITS-1:0] query_zmax;

    modport source (output valid, command, slot, load_value, query_xmin, query_ymin,
                    query_zmin, query_xmax, query_ymax, query_zmax, input ready);
    modport sink   (input valid, command, slot, load_value, query_xmin, query_ymin,
                    query_zmin, query_xmax, query_ymax, query_zmax, output ready);
endinterface

interface scbt_rsp_if;
    logic valid;
    logic ready;
    logic hits_first_box;
    logic hits_second_box;
    logic hits_shaft;

    modport source (output valid, hits_first_box, hits_second_box, hits_shaft,
                    input ready);
    modport sink   (input valid, hits_first_box, hits_second_box, hits_shaft,
                    output ready);
endinterface

[src/scbt_front.sv]
// scbt_front: stored reference boxes and the box overlap tests.
// Depends on scbt_pkg.
module scbt_front
    import scbt_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_load                        i_load,
    input  logic                         i_test,
    input  logic [TOL_W-1:0]             i_tol,
    input  logic                         i_flat,
    input  logic signed [COORD_BITS-1:0] i_qmin [3],
    input  logic signed [COORD_BITS-1:0] i_qmax [3],
    output t_tok                         o_tok,
    output logic signed [COORD_BITS-1:0] o_qmin [3],
    output logic signed [COORD_BITS-1:0] o_qmax [3]
);
    localparam int W  = COORD_BITS;
    localparam int SW = ((W > TOL_W) ? W : TOL_W) + 2;

    logic signed [W-1:0]  r_bnd [BND_SLOTS];
    logic signed [SW-1:0] w_tol;
    logic [2:0]           w_disj;
    t_tok                 r_tok;

    assign w_tol = $signed({{(SW-TOL_W){1'b0}}, i_tol});

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            w_disj[b] = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (k < 2 || !i_flat) begin
                    if (SW'(i_qmin[k]) + w_tol >= SW'(r_bnd[b*6+k+3]))
                        w_disj[b] = 1'b1;
                    if (SW'(r_bnd[b*6+k]) + w_tol >= SW'(i_qmax[k]))
                        w_disj[b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we && i_load.cmd == CMD_LOAD_BOUND) begin
            for (int s = 0; s < BND_SLOTS; s++) begin
                if (32'(i_load.slot) == s)
                    r_bnd[s] <= i_load.value[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.vld   <= i_test;
            r_tok.h1    <= !w_disj[0] && !w_disj[1];
            r_tok.h2    <= !w_disj[0] && !w_disj[2];
            r_tok.alive <= !(w_disj[0] | !w_disj[1] | !w_disj[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_qmin <= i_qmin;
        o_qmax <= i_qmax;
    end

    assign o_tok = r_tok;
endmodule

[src/scbt_cell.sv]
// scbt_cell: one shaft plane; holds its normal and offset, tests the passing box.
// Depends on scbt_pkg.
module scbt_cell
    import scbt_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int PLANE      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_load                        i_load,
    input  logic                         i_flat,
    input  logic [3:0]                   i_pcnt,
    input  t_tok                         i_tok,
    input  logic signed [COORD_BITS-1:0] i_qmin [3],
    input  logic signed [COORD_BITS-1:0] i_qmax [3],
    output t_tok                         o_tok,
    output logic signed [COORD_BITS-1:0] o_qmin [3],
    output logic signed [COORD_BITS-1:0] o_qmax [3]
);
    localparam int W  = COORD_BITS;
    localparam int NB = W + 1;
    localparam int PW = 2 * W + 1;
    localparam int AW = ((PW > LOAD_W) ? PW : LOAD_W) + 3;

    logic signed [NB-1:0]     r_norm [3];
    logic signed [LOAD_W-1:0] r_off;
    logic signed [PW-1:0]     r_prod [3];
    logic signed [PW-1:0]     n_prod [3];
    logic                     r_use;
    t_tok                     r_tok;
    logic signed [AW-1:0]     w_sum;

    always_ff @(posedge i_clk) begin
        if (i_load.we && i_load.cmd == CMD_LOAD_NORMAL) begin
            for (int k = 0; k < 3; k++) begin
                if (32'(i_load.slot) == 3 * PLANE + k)
                    r_norm[k] <= i_load.value[NB-1:0];
            end
        end
        if (i_load.we && i_load.cmd == CMD_LOAD_OFFSET && 32'(i_load.slot) == PLANE)
            r_off <= i_load.value;
    end

    // nearest corner: max coordinate where the normal is negative
    always_comb begin
        for (int k = 0; k < 3; k++)
            n_prod[k] = r_norm[k] * (r_norm[k][NB-1] ? i_qmax[k] : i_qmin[k]);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        o_qmin <= i_qmin;
        o_qmax <= i_qmax;
        r_use  <= (32'(i_pcnt) > PLANE) && !(i_flat && r_norm[2] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tok <= '0;
        else          r_tok <= i_tok;
    end

    assign w_sum = AW'(r_prod[0]) + AW'(r_prod[1]) + AW'(r_prod[2]) + AW'(r_off);

    always_comb begin
        o_tok       = r_tok;
        o_tok.alive = r_tok.alive && !(r_use && !w_sum[AW-1]);
    end
endmodule

[src/shaft_cull_box_test_top.sv]
// shaft_cull_box_test_top: shaft cull box test, top level.
// Depends on scbt_pkg, scbt_if, scbt_front, scbt_cell.
//
// Classifies a query box against one stored shaft (extent box, two end boxes,
// MAX_PLANES planes), all in Q12.12. Load beats (command 0..2) write one slot
// and give no result; out-of-range slots are dropped. A test beat enters the
// overlap stage, then walks a chain of MAX_PLANES plane cells, one cell per
// cycle; each cell owns one plane and, if that plane is in use, clears the shaft
// flag when the box's nearest corner sits on or beyond its plane. The result is
// held in an output register, and the block takes the next beat once that result
// has been taken.
// Config writes (tolerance, planar_2d, plane_count) go in while idle.
module shaft_cull_box_test_top
    import scbt_pkg::*;
#(
    parameter int MAX_PLANES = 8,
    parameter int COORD_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scbt_req_if.sink              i_req,
    scbt_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [TOL_W-1:0]      i_cfg_data
);
    localparam int W = COORD_BITS;

    logic [TOL_W-1:0] r_tol;
    logic             r_flat;
    logic [3:0]       r_pcnt;
    logic             r_busy;
    logic             r_out_vld;
    logic             r_h1, r_h2, r_hs;

    logic             w_acc;
    logic             w_test;
    t_load            w_load;

    t_tok                w_tok  [MAX_PLANES+1];
    logic signed [W-1:0] w_qmin [MAX_PLANES+1][3];
    logic signed [W-1:0] w_qmax [MAX_PLANES+1][3];
    logic signed [W-1:0] w_in_min [3];
    logic signed [W-1:0] w_in_max [3];

    // one item at a time: ready only with nothing in flight
    assign i_req.ready = !r_busy;
    assign w_acc       = i_req.valid && !r_busy;
    assign w_test      = w_acc && t_cmd'(i_req.command) == CMD_TEST;

    assign w_load.we    = w_acc && t_cmd'(i_req.command) != CMD_TEST;
    assign w_load.cmd   = t_cmd'(i_req.command);
    assign w_load.slot  = i_req.slot;
    assign w_load.value = i_req.load_value;

    assign w_in_min[0] = i_req.query_xmin;
    assign w_in_min[1] = i_req.query_ymin;
    assign w_in_min[2] = i_req.query_zmin;
    assign w_in_max[0] = i_req.query_xmax;
    assign w_in_max[1] = i_req.query_ymax;
    assign w_in_max[2] = i_req.query_zmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= '0;
            r_flat <= 1'b0;
            r_pcnt <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOLERANCE:   r_tol  <= i_cfg_data;
                CFG_PLANAR_2D:   r_flat <= i_cfg_data[0];
                CFG_PLANE_COUNT: r_pcnt <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    scbt_front #(.COORD_BITS(W)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_test (w_test),
        .i_tol  (r_tol),
        .i_flat (r_flat),
        .i_qmin (w_in_min),
        .i_qmax (w_in_max),
        .o_tok  (w_tok[0]),
        .o_qmin (w_qmin[0]),
        .o_qmax (w_qmax[0])
    );

    for (genvar p = 0; p < MAX_PLANES; p++) begin : g_cell
        scbt_cell #(.COORD_BITS(W), .PLANE(p)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_load (w_load),
            .i_flat (r_flat),
            .i_pcnt (r_pcnt),
            .i_tok  (w_tok[p]),
            .i_qmin (w_qmin[p]),
            .i_qmax (w_qmax[p]),
            .o_tok  (w_tok[p+1]),
            .o_qmin (w_qmin[p+1]),
            .o_qmax (w_qmax[p+1])
        );
    end

    // result register; frees the block once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_test)
                r_busy <= 1'b1;
            if (w_tok[MAX_PLANES].vld)
                r_out_vld <= 1'b1;
            else if (r_out_vld && o_rsp.ready) begin
                r_out_vld <= 1'b0;
                r_busy    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[MAX_PLANES].vld) begin
            r_h1 <= w_tok[MAX_PLANES].h1;
            r_h2 <= w_tok[MAX_PLANES].h2;
            r_hs <= w_tok[MAX_PLANES].alive
                    ^ (w_qmin[MAX_PLANES][0] != w_qmin[MAX_PLANES][0])
                    ^ (w_qmax[MAX_PLANES][0] != w_qmax[MAX_PLANES][0]);
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.hits_first_box  = r_h1;
    assign o_rsp.hits_second_box = r_h2;
    assign o_rsp.hits_shaft      = r_hs;
endmodule

[src/scbt_chk.sv]
// scbt_chk: port-level checks for shaft_cull_box_test_top, bound to it below.
// Depends on scbt_if signals through the bind connections.
module scbt_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_h1,
    input logic i_h2,
    input logic i_hs
);
    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_h1, i_h2, i_hs}))
        else $error("result beat dropped or changed while stalled");

    // an end box hit excludes a shaft hit
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_hs && (i_h1 || i_h2)))
        else $error("shaft hit reported together with end box hit");

    // no new beat taken while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // result beat never appears the cycle after an input beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared too early");
endmodule

bind shaft_cull_box_test_top scbt_chk u_scbt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_h1       (o_rsp.hits_first_box),
    .i_h2       (o_rsp.hits_second_box),
    .i_hs       (o_rsp.hits_shaft)
);

[dv/shaft_cull_box_test_top_test.sv]
// Self-checking testbench for shaft_cull_box_test_top: loads shafts, streams query boxes.
// Depends on scbt_pkg, scbt_if and the block's RTL; predicts each result in-bench.
module shaft_cull_box_test_top_test;
    import scbt_pkg::*;

    localparam int NPL = 8;
    localparam int CB  = 24;

    typedef struct {
        bit h1;
        bit h2;
        bit hs;
    } t_flags;

    // holds pending flag triples and the mirrored shaft state
    class cull_scoreboard;
        t_flags      pending[$];
        int          mismatches;
        int          errors;
        longint      bnd[BND_SLOTS];
        longint      nrm[3*NPL];
        longint      ofs[NPL];
        int unsigned tol;
        bit          flat;
        int unsigned pcnt;

        function bit apart(longint q[6], int b);
            int ax;
            longint t;
            ax = flat ? 2 : 3;
            t = longint'(tol);
            for (int k = 0; k < ax; k++) begin
                if (q[k] + t >= bnd[b*6+k+3]) return 1;
                if (bnd[b*6+k] + t >= q[k+3]) return 1;
            end
            return 0;
        endfunction

        // note an accepted beat: update state for loads, queue flags for tests
        function void note_beat(t_cmd c, int s, logic [LOAD_W-1:0] v, longint q[6]);
            t_flags f;
            int n;
            logic signed [127:0] sum;
            case (c)
                CMD_LOAD_BOUND:  if (s < BND_SLOTS) bnd[s] = longint'($signed(v[CB-1:0]));
                CMD_LOAD_NORMAL: if (s < 3*NPL) nrm[s] = longint'($signed(v[CB:0]));
                CMD_LOAD_OFFSET: if (s < NPL) ofs[s] = longint'($signed(v));
                default: begin
                    f = '{0, 0, 0};
                    if (!apart(q, 0)) begin
                        f.h1 = !apart(q, 1);
                        f.h2 = !apart(q, 2);
                        if (!(f.h1 | f.h2)) begin
                            f.hs = 1;
                            n = (pcnt > NPL) ? NPL : pcnt;
                            for (int p = 0; p < n; p++) begin
                                if (flat && nrm[p*3+2] != 0) continue;
                                sum = ofs[p];
                                // nearest corner: max side for negative normals
                                for (int k = 0; k < 3; k++)
                                    sum += nrm[p*3+k] * (nrm[p*3+k] < 0 ? q[k+3] : q[k]);
                                if (sum >= 0) begin
                                    f.hs = 0;
                                    break;
                                end
                            end
                        end
                    end
                    pending.push_back(f);
                end
            endcase
        endfunction

        function void check_result(bit h1, bit h2, bit hs);
            t_flags e;
            if (pending.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result beat %b%b%b", h1, h2, hs);
                return;
            end
            e = pending.pop_front();
            if (e.h1 !== h1 || e.h2 !== h2 || e.hs !== hs) begin
                errors++;
                if (mismatches++ < 10)
                    $display("flags mismatch: exp %b%b%b got %b%b%b",
                             e.h1, e.h2, e.hs, h1, h2, hs);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TOL_W-1:0] i_cfg_data = '0;

    scbt_req_if #(.COORD_BITS(CB)) req_if ();
    scbt_rsp_if rsp_if ();

    shaft_cull_box_test_top #(.MAX_PLANES(NPL), .COORD_BITS(CB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    cull_scoreboard sb = new();
    bit rsp_stall_on = 1;

    initial begin
        req_if.valid = 0;
        req_if.command = '0;
        req_if.slot = '0;
        req_if.load_value = '0;
        {req_if.query_xmin, req_if.query_ymin, req_if.query_zmin} = '0;
        {req_if.query_xmax, req_if.query_ymax, req_if.query_zmax} = '0;
        rsp_if.ready = 0;
    end

    // sink side: random stall before each result beat, when stalls are enabled
    initial begin : rsp_side
        int gap;
        forever begin
            gap = rsp_stall_on ? $urandom_range(0, 4) : 0;
            if (gap != 0) begin
                rsp_if.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            sb.check_result(rsp_if.hits_first_box, rsp_if.hits_second_box,
                            rsp_if.hits_shaft);
        end
    end

    bit drv_gaps = 1;
    int next_gap = 0;

    // one input beat; waits for acceptance, predicts at the handshake edge
    task automatic send_beat(t_cmd c, int s, logic [LOAD_W-1:0] v, longint q[6]);
        repeat (next_gap) @(posedge i_clk);
        req_if.valid <= 1;
        req_if.command <= c;
        req_if.slot <= s[SLOT_W-1:0];
        req_if.load_value <= v;
        req_if.query_xmin <= q[0][CB-1:0];
        req_if.query_ymin <= q[1][CB-1:0];
        req_if.query_zmin <= q[2][CB-1:0];
        req_if.query_xmax <= q[3][CB-1:0];
        req_if.query_ymax <= q[4][CB-1:0];
        req_if.query_zmax <= q[5][CB-1:0];
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_beat(c, s, v, q);
        // valid stays up only when the next beat follows at once
        next_gap = drv_gaps ? $urandom_range(0, 4) : 0;
        if (next_gap != 0) req_if.valid <= 0;
    endtask

    // drop valid when the last beat left it up
    task automatic req_idle();
        if (next_gap == 0) req_if.valid <= 0;
    endtask

    function automatic longint rnd_coord(int span);
        return longint'($urandom_range(0, 2*span)) - span;
    endfunction

    function automatic logic [LOAD_W-1:0] rnd_wide();
        return LOAD_W'({$urandom(), $urandom()});
    endfunction

    task automatic load_item(t_cmd c, int s, logic [LOAD_W-1:0] v);
        longint q[6];
        foreach (q[k]) q[k] = rnd_coord(8388608 - 1);
        send_beat(c, s, v, q);
    endtask

    task automatic test_box(longint q[6]);
        send_beat(CMD_TEST, $urandom_range(0, 31), rnd_wide(), q);
    endtask

    // block must be idle before register writes; drain plus chain latency
    task automatic cfg_write(t_cfg_idx idx, int unsigned val);
        req_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (NPL + 6) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[TOL_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_TOLERANCE:   sb.tol = val[TOL_W-1:0];
            CFG_PLANAR_2D:   sb.flat = val[0];
            CFG_PLANE_COUNT: sb.pcnt = val[3:0];
            default: ;
        endcase
    endtask

    // new shaft: all slots written so no undefined entry is ever read
    task automatic load_shaft(int span);
        longint a, b;
        for (int bx = 0; bx < 3; bx++)
            for (int k = 0; k < 3; k++) begin
                a = rnd_coord(span);
                b = rnd_coord(span);
                if (a > b) begin
                    a = a ^ b; b = a ^ b; a = a ^ b;
                end
                load_item(CMD_LOAD_BOUND, bx*6+k,
                          LOAD_W'(a) ^ LOAD_W'({rnd_wide() >> CB, CB'(0)}));
                load_item(CMD_LOAD_BOUND, bx*6+k+3, LOAD_W'(b));
            end
        for (int s = 0; s < 3*NPL; s++)
            load_item(CMD_LOAD_NORMAL, s,
                      ($urandom_range(0, 3) == 0) ? '0 : LOAD_W'(rnd_coord(1 << 13)));
        for (int p = 0; p < NPL; p++)
            load_item(CMD_LOAD_OFFSET, p, ($urandom_range(0, 5) == 0) ? rnd_wide()
                      : LOAD_W'(rnd_coord(1 << 30) * 64));
    endtask

    task automatic rnd_box(int span);
        longint q[6], a, b;
        for (int k = 0; k < 3; k++) begin
            a = rnd_coord(span);
            b = a + $urandom_range(0, span);
            if (b > 8388607) b = 8388607;
            if ($urandom_range(0, 15) == 0) begin
                a = rnd_coord(8388607);
                b = rnd_coord(8388607);
            end
            q[k] = a;
            q[k+3] = b;
        end
        test_box(q);
    endtask

    initial begin : stim
        longint q[6];
        int span;
        // full-range extremes, first pass with the default config
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        load_shaft(8388607);
        // extent box maximal so most tests pass the first stage
        load_item(CMD_LOAD_BOUND, 0, LOAD_W'(-8388608));
        load_item(CMD_LOAD_BOUND, 1, LOAD_W'(-8388608));
        load_item(CMD_LOAD_BOUND, 2, LOAD_W'(-8388608));
        load_item(CMD_LOAD_BOUND, 3, LOAD_W'(8388607));
        load_item(CMD_LOAD_BOUND, 4, LOAD_W'(8388607));
        load_item(CMD_LOAD_BOUND, 5, LOAD_W'(8388607));
        // out-of-range slots are dropped
        load_item(CMD_LOAD_BOUND, 31, '1);
        load_item(CMD_LOAD_NORMAL, 24, '1);
        load_item(CMD_LOAD_OFFSET, 8, '1);
        // zero planes in use
        q = '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607};
        test_box(q);
        q = '{-100, -100, -100, -100, -100, -100};
        test_box(q);
        // boundary touch against the extent
        q = '{8388607, 0, 0, 8388607, 1, 1};
        test_box(q);
        cfg_write(CFG_PLANE_COUNT, 15);   // saturates
        cfg_write(CFG_TOLERANCE, 8388607);
        test_box(q);
        q = '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607};
        test_box(q);
        cfg_write(CFG_TOLERANCE, 0);
        cfg_write(CFG_PLANAR_2D, 1);
        test_box(q);
        q = '{0, 0, -8388608, 0, 0, 8388607};
        test_box(q);
        cfg_write(CFG_PLANAR_2D, 0);
        // plane exactly on the corner: normal x=1 offset 0 -> sum 0 -> outside
        cfg_write(CFG_PLANE_COUNT, 1);
        load_item(CMD_LOAD_NORMAL, 0, 1);
        load_item(CMD_LOAD_NORMAL, 1, 0);
        load_item(CMD_LOAD_NORMAL, 2, 0);
        load_item(CMD_LOAD_OFFSET, 0, 0);
        load_item(CMD_LOAD_BOUND, 6, LOAD_W'(8388600));
        load_item(CMD_LOAD_BOUND, 9, LOAD_W'(8388601));
        load_item(CMD_LOAD_BOUND, 12, LOAD_W'(8388600));
        load_item(CMD_LOAD_BOUND, 15, LOAD_W'(8388601));
        q = '{0, 0, 0, 5, 5, 5};
        test_box(q);
        q = '{-5, 0, 0, 5, 5, 5};
        test_box(q);

        // random phases: new settings, new shaft, then mostly tests
        for (int ph = 0; ph < 12; ph++) begin
            span = ($urandom_range(0, 2) == 0) ? 8388607 : (1 << $urandom_range(10, 22));
            cfg_write(CFG_TOLERANCE, (ph % 5 == 0) ? 0 : (ph % 5 == 1) ? 8388607
                      : $urandom_range(0, 1 << $urandom_range(0, 16)));
            cfg_write(CFG_PLANAR_2D, $urandom_range(0, 1));
            cfg_write(CFG_PLANE_COUNT, (ph % 4 == 0) ? 0 : $urandom_range(1, 15));
            drv_gaps = (ph % 6 != 3);
            rsp_stall_on = (ph % 6 != 4);
            load_shaft(span);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 19) == 0)
                    load_item(t_cmd'($urandom_range(0, 2)), $urandom_range(0, 31),
                              rnd_wide());
                else
                    rnd_box(span);
            end
        end
        req_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (NPL + 10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
